@@ hdl/appliance_frame_receiver_top_macros.svh @@
// Assertion macros used by the frame receiver parser
`ifndef APPLIANCE_FRAME_RECEIVER_TOP_MACROS_SVH
`define APPLIANCE_FRAME_RECEIVER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset
`define AFR_ASSERT_IMP(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error(msg);

// Next-cycle implication, disabled during reset
`define AFR_ASSERT_NXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error(msg);

`endif

@@ hdl/afr_pkg.sv @@
// Types and constants of the appliance frame receiver
package afr_pkg;

  localparam logic [7:0] START_BYTE       = 8'hAA;
  localparam logic [7:0] MIN_LENGTH       = 8'd3;
  localparam logic [7:0] MAX_LENGTH_RESET = 8'hFF;
  localparam logic [7:0] IDX_START        = 8'd0;
  localparam logic [7:0] IDX_LENGTH       = 8'd1;
  localparam logic [7:0] IDX_TYPE         = 8'd2;
  localparam logic [7:0] IDX_SYNC         = 8'd3;

  localparam int unsigned PADDR_W = 3;
  localparam logic REG_MAX_LENGTH = 1'b0;

  typedef enum logic [2:0] {
    PH_HUNT   = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef enum logic [2:0] {
    ST_BUSY     = 3'd0,
    ST_GOOD     = 3'd1,
    ST_SYNC_BAD = 3'd2,
    ST_SUM_BAD  = 3'd3,
    ST_NO_START = 3'd4,
    ST_LEN_BAD  = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    logic       frame_last;
    status_t    status;
  } result_t;

endpackage

@@ hdl/afr_stream_if.sv @@
// Valid/ready channels for received bytes and echoed results
interface afr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface afr_out_if;
  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic [7:0]       byte_index;
  logic             frame_last;
  afr_pkg::status_t status;

  modport source (output valid, output data_byte, output byte_index,
                  output frame_last, output status, input ready);
  modport sink (input valid, input data_byte, input byte_index,
                input frame_last, input status, output ready);
endinterface

@@ hdl/afr_parser.sv @@
// Frame parser state and per-byte result logic
module afr_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        rx_byte,
  input  logic [7:0]        max_length,
  output afr_pkg::result_t  result
);
  import afr_pkg::*;
  `include "appliance_frame_receiver_top_macros.svh"

  phase_t     phase, phase_next;
  logic [7:0] position, position_next;
  logic [7:0] frame_length, frame_length_next;
  logic [7:0] running_sum, running_sum_next;
  logic [7:0] type_byte, type_byte_next;
  logic       sync_check_ok, sync_check_ok_next;

  always_comb begin
    phase_next         = phase;
    position_next      = position;
    frame_length_next  = frame_length;
    running_sum_next   = running_sum;
    type_byte_next     = type_byte;
    sync_check_ok_next = sync_check_ok;
    result.data_byte   = rx_byte;
    result.byte_index  = IDX_START;
    result.frame_last  = 1'b0;
    result.status      = ST_BUSY;
    case (phase)
      PH_LENGTH: begin
        result.byte_index = IDX_LENGTH;
        if ((rx_byte < MIN_LENGTH) || (rx_byte > max_length)) begin
          result.frame_last = 1'b1;
          result.status     = ST_LEN_BAD;
          phase_next        = PH_HUNT;
        end else begin
          frame_length_next = rx_byte;
          running_sum_next  = rx_byte;
          position_next     = IDX_TYPE;
          phase_next        = PH_BODY;
        end
      end
      PH_BODY: begin
        result.byte_index = position;
        if (position == IDX_TYPE) begin
          type_byte_next = rx_byte;
        end
        if (position == IDX_SYNC) begin
          sync_check_ok_next = (rx_byte == (frame_length ^ type_byte));
        end
        if (position >= frame_length) begin
          result.frame_last = 1'b1;
          phase_next        = PH_HUNT;
          if (!sync_check_ok_next) begin
            result.status = ST_SYNC_BAD;
          end else if (rx_byte == (8'd0 - running_sum)) begin
            result.status = ST_GOOD;
          end else begin
            result.status = ST_SUM_BAD;
          end
        end else begin
          running_sum_next = running_sum + rx_byte;
          position_next    = position + 8'd1;
        end
      end
      default: begin
        if (rx_byte == START_BYTE) begin
          phase_next         = PH_LENGTH;
          position_next      = IDX_LENGTH;
          sync_check_ok_next = 1'b0;
          type_byte_next     = 8'd0;
          running_sum_next   = 8'd0;
        end else begin
          phase_next        = PH_HUNT;
          result.frame_last = 1'b1;
          result.status     = ST_NO_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      position      <= 8'd0;
      frame_length  <= 8'd0;
      running_sum   <= 8'd0;
      type_byte     <= 8'd0;
      sync_check_ok <= 1'b0;
    end else if (accept) begin
      phase         <= phase_next;
      position      <= position_next;
      frame_length  <= frame_length_next;
      running_sum   <= running_sum_next;
      type_byte     <= type_byte_next;
      sync_check_ok <= sync_check_ok_next;
    end
  end

  `AFR_ASSERT_NXT(a_start_to_length,
    accept && (phase == PH_HUNT) && (rx_byte == START_BYTE),
    phase == PH_LENGTH, "start byte did not advance to length phase")
  `AFR_ASSERT_NXT(a_last_to_hunt, accept && result.frame_last,
    phase == PH_HUNT, "frame end did not return to hunting")
  `AFR_ASSERT_IMP(a_body_position, phase == PH_BODY,
    (position >= IDX_TYPE) && (position <= frame_length),
    "body position outside frame")

endmodule

@@ hdl/appliance_frame_receiver_top.sv @@
// Top level of the appliance frame receiver with APB register and output stage
// Usage:
//   in_ch carries received serial bytes (rx_byte); a request is taken when
//   valid and ready are both high. out_ch returns one result per byte: the
//   byte echoed, its position in the frame (start byte at 0), a frame_last
//   flag and a status (in progress, good, sync bad, checksum bad, no start,
//   length bad).
//   out_ch.valid rises in the cycle after acceptance; throughput is one byte
//   per cycle while out_ch.ready is high, one parser state update per byte.
//   When out_ch.ready is low, the held result stays in the output register and
//   in_ch.ready drops until the result is taken; a new byte is accepted in the
//   same cycle the held result leaves.
//   The APB port holds max_length at addresses 0 to 3 (reset 255); write it
//   only while idle.
//   Reset (rst, synchronous) returns the parser to hunting for the start byte
//   and empties the output register.
module appliance_frame_receiver_top (
  input  logic                         clk,
  input  logic                         rst,
  afr_in_if.sink                       in_ch,
  afr_out_if.source                    out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [afr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);
  import afr_pkg::*;

  logic       max_length_sel;
  logic [7:0] max_length;
  logic       accept;
  logic       out_valid;
  result_t    result;
  result_t    out_data;

  assign pready         = 1'b1;
  assign max_length_sel = (paddr[PADDR_W-1] == REG_MAX_LENGTH);
  assign prdata         = max_length_sel ? {24'd0, max_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_length <= MAX_LENGTH_RESET;
    end else if (psel && penable && pwrite && pready && max_length_sel) begin
      max_length <= pwdata[7:0];
    end
  end

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;

  afr_parser u_parser (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (in_ch.rx_byte),
    .max_length (max_length),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= result;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.data_byte  = out_data.data_byte;
  assign out_ch.byte_index = out_data.byte_index;
  assign out_ch.frame_last = out_data.frame_last;
  assign out_ch.status     = out_data.status;

endmodule

@@ sim/tb_appliance_frame_receiver_top.sv @@
// Self-checking testbench for the appliance frame receiver: frames, errors, flow control, APB
module tb_appliance_frame_receiver_top;
  timeunit 1ns;
  timeprecision 1ps;
  import afr_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int HOLD_CYCLES = 200;
  localparam int NUM_PHASES = 8;
  localparam logic [PADDR_W-1:0] MAX_LENGTH_ADDR = {REG_MAX_LENGTH, 2'b00};

  class frame_scoreboard;
    phase_t     parse_phase;
    logic [7:0] next_pos;
    logic [7:0] frame_len;
    logic [7:0] body_sum;
    logic [7:0] type_val;
    logic [7:0] max_len;
    bit         sync_ok;
    result_t    pending_echoes[$];
    int         errors;
    int         checked;
    int         status_seen[8];

    function new();
      max_len = MAX_LENGTH_RESET;
      parse_phase = PH_HUNT;
      next_pos = '0;
      frame_len = '0;
      body_sum = '0;
      type_val = '0;
      sync_ok = 1'b0;
      errors = 0;
      checked = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function result_t parse_byte(logic [7:0] b);
      result_t    r;
      logic [7:0] neg_sum;
      r.data_byte = b;
      r.byte_index = IDX_START;
      r.frame_last = 1'b0;
      r.status = ST_BUSY;
      case (parse_phase)
        PH_LENGTH: begin
          r.byte_index = IDX_LENGTH;
          if (b < MIN_LENGTH || b > max_len) begin
            r.frame_last = 1'b1;
            r.status = ST_LEN_BAD;
            parse_phase = PH_HUNT;
          end else begin
            frame_len = b;
            body_sum = b;
            next_pos = IDX_TYPE;
            parse_phase = PH_BODY;
          end
        end
        PH_BODY: begin
          r.byte_index = next_pos;
          if (next_pos == IDX_TYPE) type_val = b;
          if (next_pos == IDX_SYNC) sync_ok = (b == (frame_len ^ type_val));
          if (next_pos >= frame_len) begin
            neg_sum = 8'd0 - body_sum;
            r.frame_last = 1'b1;
            if (!sync_ok) r.status = ST_SYNC_BAD;
            else if (b == neg_sum) r.status = ST_GOOD;
            else r.status = ST_SUM_BAD;
            parse_phase = PH_HUNT;
          end else begin
            body_sum = body_sum + b;
            next_pos = next_pos + 8'd1;
          end
        end
        default: begin
          if (b == START_BYTE) begin
            parse_phase = PH_LENGTH;
            next_pos = IDX_LENGTH;
            sync_ok = 1'b0;
            type_val = '0;
            body_sum = '0;
          end else begin
            parse_phase = PH_HUNT;
            r.frame_last = 1'b1;
            r.status = ST_NO_START;
          end
        end
      endcase
      return r;
    endfunction

    function void note_request(logic [7:0] b);
      pending_echoes.push_back(parse_byte(b));
    endfunction

    function void check_result(result_t act);
      result_t exp;
      if (pending_echoes.size() == 0) begin
        errors++;
        $display("%0t: unexpected echo data=%h idx=%0d last=%b status=%0d, none expected",
                 $time, act.data_byte, act.byte_index, act.frame_last, act.status);
      end else begin
        exp = pending_echoes.pop_front();
        checked++;
        status_seen[exp.status]++;
        if (act !== exp) begin
          errors++;
          $display("%0t: echo mismatch expected data=%h idx=%0d last=%b status=%0d",
                   $time, exp.data_byte, exp.byte_index, exp.frame_last, exp.status);
          $display("%0t:                 actual data=%h idx=%0d last=%b status=%0d",
                   $time, act.data_byte, act.byte_index, act.frame_last, act.status);
        end
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;

  afr_in_if  in_ch ();
  afr_out_if out_ch ();

  frame_scoreboard sb;
  longint cycle_count = 0;
  int     bytes_sent = 0;
  int     source_idle_pct = 0;
  int     sink_stall_pct = 0;
  int     hold_requests = 0;
  int     holds_served = 0;
  int     hold_left = 0;

  appliance_frame_receiver_top DUT (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d echoes outstanding",
               cycle_count, sb.pending_echoes.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (holds_served != hold_requests) begin
        holds_served <= holds_served + 1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result('{out_ch.data_byte, out_ch.byte_index, out_ch.frame_last, out_ch.status});
  end

  task automatic send_request(input logic [7:0] b);
    if (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < source_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.rx_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(b);
    bytes_sent++;
  endtask

  task automatic send_frame(input int len, input bit bad_sync, input bit bad_sum);
    logic [7:0] frame[$];
    logic [7:0] sum;
    logic [7:0] kind;
    kind = 8'($urandom);
    frame = {START_BYTE, 8'(len), kind};
    frame.push_back((8'(len) ^ kind) ^ (bad_sync ? 8'($urandom_range(1, 255)) : 8'd0));
    for (int i = 4; i < len; i++) frame.push_back(8'($urandom));
    if (len > MIN_LENGTH) begin
      sum = '0;
      for (int i = 1; i < frame.size(); i++) sum = sum + frame[i];
      frame.push_back((8'd0 - sum) + (bad_sum ? 8'($urandom_range(1, 255)) : 8'd0));
    end
    foreach (frame[i]) send_request(frame[i]);
  endtask

  task automatic send_random(input int budget);
    int stop_at;
    int pick;
    int hi;
    int len;
    stop_at = bytes_sent + budget;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(99);
      hi = (sb.max_len >= MIN_LENGTH) ? int'(sb.max_len) : 12;
      if (pick < 8) begin
        send_request(8'($urandom));
      end else if (pick < 16) begin
        send_request(START_BYTE);
        if (sb.max_len != 8'hFF && $urandom_range(1) == 1)
          send_request(8'($urandom_range(int'(sb.max_len) + 1, 255)));
        else
          send_request(8'($urandom_range(0, MIN_LENGTH - 1)));
      end else begin
        if ($urandom_range(39) == 0) len = hi;
        else len = $urandom_range(MIN_LENGTH, (hi < 12) ? hi : 12);
        pick = $urandom_range(9);
        send_frame(len, pick == 0 || pick == 2, pick == 1 || pick == 2);
      end
    end
  endtask

  task automatic drain_echoes();
    in_ch.valid <= 1'b0;
    while (sb.pending_echoes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [7:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= MAX_LENGTH_ADDR;
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      sb.errors++;
      $display("%0t: max_length readback expected %h, actual %h", $time, value, prdata[7:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    sb.max_len = value;
  endtask

  initial begin
    logic [7:0] phase_max[NUM_PHASES];
    int         phase_budget[NUM_PHASES];
    sb = new();
    phase_max = '{8'hFF, 8'd10, 8'd3, 8'd0, 8'd40, 8'd2, 8'hFF, 8'd4};
    phase_budget = '{120, 130, 110, 40, 130, 40, 130, 130};
    phase_max[4] = 8'($urandom_range(4, 60));
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.rx_byte <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_echoes();
      write_max_length(phase_max[ph]);
      case (ph % 4)
        0: begin
          source_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          source_idle_pct = 62;
          sink_stall_pct <= 0;
        end
        2: begin
          source_idle_pct = 0;
          sink_stall_pct <= 62;
        end
        default: begin
          source_idle_pct = 16;
          sink_stall_pct <= 16;
        end
      endcase
      if (ph == 0) begin
        send_request(8'h00);
        send_request(8'hFF);
        send_request(START_BYTE);
        send_request(MIN_LENGTH - 8'd1);
        send_request(START_BYTE);
        send_request(8'd0);
        send_frame(4, 1'b0, 1'b0);
        send_frame(3, 1'b0, 1'b0);
        send_frame(4, 1'b1, 1'b0);
        send_frame(4, 1'b0, 1'b1);
      end
      if (ph == 4) hold_requests <= hold_requests + 1;
      send_random(phase_budget[ph]);
    end

    drain_echoes();
    repeat (10) @(posedge clk);
    $display("Checked %0d echoes of %0d bytes across %0d max_length settings, 0 to 255",
             sb.checked, bytes_sent, NUM_PHASES);
    $display("Frames good %0d, sync bad %0d, checksum bad %0d, length bad %0d, stray %0d",
             sb.status_seen[ST_GOOD], sb.status_seen[ST_SYNC_BAD], sb.status_seen[ST_SUM_BAD],
             sb.status_seen[ST_LEN_BAD], sb.status_seen[ST_NO_START]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/afr_pkg.sv
hdl/afr_stream_if.sv
hdl/afr_parser.sv
hdl/appliance_frame_receiver_top.sv
sim/tb_appliance_frame_receiver_top.sv
